### rtl/bls_pkg.sv
// Shared types and codes for the bounded LIFO stack.
package bls_pkg;

  localparam int DataW = 32;
  localparam int CapW  = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  // Request codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_DUMP = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DataW-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic [1:0]              status;
    logic                    last;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_DATA
  } state_t;

endpackage

### rtl/bls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bounded_lifo_stack_top.sv
// Top level of the bounded LIFO stack: control, fill count and result register.
//
// Bounded LIFO stack of signed 32-bit words held in one synchronous RAM of DEPTH
// entries (bottom at address 0). Requests arrive on the req channel (push, pop,
// peek, dump) and results leave on the rsp channel, both valid/ready; one request
// is handled at a time. Push and a request on an empty stack pass through S_EMIT
// before the next transfer, since the result goes through the output register;
// pop and peek pass through S_DATA, which emits the RAM read data. A dump of n
// entries stays in S_DATA: one RAM read per entry, top first, with last set on
// the bottom entry. The next request is taken while the previous result still
// sits in the output register. capacity_limit (cfg_wdata, written on cfg_we,
// reset 64) caps the usable entries and saturates at DEPTH; lowering it below
// the fill only blocks further pushes. Errors return data zero with status full
// or empty. Write the register only while the block is idle.
module bounded_lifo_stack_top #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bls_pkg::req_t      req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output bls_pkg::rsp_t      rsp,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);

  import bls_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  // Control state
  state_t          state, state_next;
  logic [FW-1:0]   fill, fill_next;      // stored entries
  logic [CapW-1:0] cap;                  // capacity_limit register

  // Per-request working registers
  logic [AW-1:0]   idx, idx_next;        // address of the entry in flight
  logic            is_dump, is_dump_next;
  logic [1:0]      res_status, res_status_next;

  // RAM port
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_rdata;

  // Output register
  logic  out_load;
  rsp_t  out_next;

  logic req_xfer, slot_free, full, empty;

  assign req_xfer  = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  // Full when fill reaches the limit or the physical depth (saturation).
  assign full      = (CapW'(fill) >= cap) || (fill == FW'(DEPTH));
  assign empty     = (fill == '0);

  bls_ram #(
    .WIDTH(DataW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req.push_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          case (req.op)
            OP_PUSH: state_next = S_EMIT;
            default: state_next = empty ? S_EMIT : S_DATA;
          endcase
        end
      end
      S_EMIT: begin
        if (slot_free) state_next = S_IDLE;
      end
      S_DATA: begin
        // dump stays here until the bottom entry goes out
        if (slot_free && !(is_dump && idx != '0)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath controls and results
  always_comb begin
    req_ready       = (state == S_IDLE);
    ram_we          = 1'b0;
    ram_waddr       = fill[AW-1:0];
    ram_re          = 1'b0;
    ram_raddr       = idx;
    fill_next       = fill;
    idx_next        = idx;
    is_dump_next    = is_dump;
    res_status_next = res_status;
    out_load        = 1'b0;
    out_next        = '{data: '0, status: res_status, last: 1'b1};

    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          idx_next     = (fill - FW'(1)) > FW'(0) ? AW'(fill - FW'(1)) : '0;
          is_dump_next = (req.op == OP_DUMP);
          ram_raddr    = idx_next;
          case (req.op)
            OP_PUSH: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                res_status_next = ST_OK;
                ram_we          = 1'b1;
                fill_next       = fill + FW'(1);
              end
            end
            default: begin
              if (empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                ram_re = 1'b1;
                if (req.op == OP_POP) fill_next = fill - FW'(1);
              end
            end
          endcase
        end
      end
      S_EMIT: begin
        out_load = slot_free;
      end
      S_DATA: begin
        out_load = slot_free;
        out_next = '{data: ram_rdata, status: ST_OK, last: !is_dump || idx == '0};
        // next lower entry for a dump
        if (slot_free && is_dump && idx != '0) begin
          idx_next  = idx - AW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_next;
        end
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cap       <= CapReset;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_we) cap <= cfg_wdata;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    is_dump    <= is_dump_next;
    res_status <= res_status_next;
    if (out_load) rsp <= out_next;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("fill count above depth");

  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req.op == OP_PUSH && !full) |=> (fill == $past(fill) + FW'(1)))
    else $error("accepted push did not grow the stack");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req.op == OP_POP && !empty) |=> (fill == $past(fill) - FW'(1)))
    else $error("accepted pop did not shrink the stack");

  a_load_state: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == S_EMIT || state == S_DATA))
    else $error("result loaded outside a result state");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the bounded LIFO stack top level.
`timescale 1ns / 100ps

module tb;
  import bls_pkg::*;

  localparam int StackDepth  = 64;
  localparam int StallLimit  = 4000;  // cycles with no transfer before giving up
  localparam int DrainCycles = 8;     // settle time once every result is back
  localparam int NumSegs     = 6;
  localparam int SegItems    = 50;
  localparam int MaxPrints   = 40;

  localparam logic signed [DataW-1:0] WordMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] WordMin = {1'b1, {(DataW-1){1'b0}}};

  // Shadow copy of the stack: predicts results per request, checks them in order.
  class stack_shadow;
    logic signed [DataW-1:0] words[StackDepth];
    int unsigned             fill;
    logic [CapW-1:0]         cap_limit;
    rsp_t                    pending_rsp[$];
    int                      error_count;

    function new();
      fill        = 0;
      cap_limit   = CapReset;
      error_count = 0;
    endfunction

    function void set_capacity(logic [CapW-1:0] value);
      cap_limit = value;
    endfunction

    // capacity register saturates at the storage depth
    function int unsigned usable_slots();
      return (cap_limit > StackDepth) ? StackDepth : cap_limit;
    endfunction

    function void queue_rsp(logic signed [DataW-1:0] d, logic [1:0] st, logic lst);
      rsp_t r;
      r.data   = d;
      r.status = st;
      r.last   = lst;
      pending_rsp.push_back(r);
    endfunction

    function void note_request(req_t r);
      case (r.op)
        OP_PUSH: begin
          if (fill >= usable_slots()) begin
            queue_rsp('0, ST_FULL, 1'b1);
          end else begin
            words[fill] = r.push_value;
            fill++;
            queue_rsp('0, ST_OK, 1'b1);
          end
        end
        OP_POP, OP_PEEK: begin
          if (fill == 0) begin
            queue_rsp('0, ST_EMPTY, 1'b1);
          end else begin
            queue_rsp(words[fill-1], ST_OK, 1'b1);
            if (r.op == OP_POP) fill--;
          end
        end
        OP_DUMP: begin
          if (fill == 0) begin
            queue_rsp('0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = int'(fill) - 1; i >= 0; i--)
              queue_rsp(words[i], ST_OK, i == 0);
          end
        end
      endcase
    endfunction

    task report_mismatch(string what);
      if (error_count < MaxPrints) $display("%0t MISMATCH: %s", $time, what);
      error_count++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%0d status=%0d last=%0b",
                                  got.data, got.status, got.last));
        return;
      end
      want = pending_rsp.pop_front();
      if (got.data !== want.data)
        report_mismatch($sformatf("data %0d, want %0d", got.data, want.data));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic            clk;
  logic            rst       = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_ready;
  req_t            req       = '0;
  logic            rsp_valid;
  logic            rsp_ready = 1'b0;
  rsp_t            rsp;
  logic            cfg_we    = 1'b0;
  logic [CapW-1:0] cfg_wdata = '0;

  stack_shadow shadow = new();

  // Transfer counters, bumped at the rising edge and read by the drivers on the
  // falling edge, so no driver ever races the monitor.
  int unsigned req_xfers    = 0;
  int unsigned rsp_xfers    = 0;
  int unsigned quiet_cycles = 0;

  // Idle rates in percent, changed per phase by the stimulus.
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 86;

  // Random phases: capacity, push share, and idle rates of both sides.
  // Carried fill matters: the 127 phase pushes hard to hit the saturated
  // limit, then the 5 phase sits below the fill and drains it.
  int seg_cap      [NumSegs] = '{1, 64, 127, 5, 0, 20};
  int seg_push_pct [NumSegs] = '{50, 70, 85, 20, 40, 55};
  int seg_send_idle[NumSegs] = '{18, 18, 86, 86, 0, 0};
  int seg_recv_idle[NumSegs] = '{86, 86, 18, 18, 0, 0};

  bounded_lifo_stack_top #(
    .DEPTH(StackDepth)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: predict on every request transfer, check on every result transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        shadow.note_request(req);
        req_xfers++;
      end
      if (rsp_valid && rsp_ready) begin
        shadow.check_result(rsp);
        rsp_xfers++;
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Receiver: random back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    rsp_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: no transfer on either channel for too long means a hang.
  initial begin
    while (quiet_cycles < StallLimit) @(negedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one request and hold it until the transfer. Called on a falling edge.
  // Valid is only lowered when a gap is taken, so back-to-back requests keep
  // it high with a single assignment per step.
  task automatic send_req(logic [1:0] op, logic signed [DataW-1:0] value);
    int unsigned seen;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    seen = req_xfers;
    req       <= '{op: op, push_value: value};
    req_valid <= 1'b1;
    do @(negedge clk); while (req_xfers == seen);
  endtask

  // Register writes only with the block idle: every result back, then a pause
  // for a dump that might still be winding down.
  task automatic write_capacity(logic [CapW-1:0] value);
    req_valid <= 1'b0;
    while (shadow.pending_rsp.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow.set_capacity(value);
  endtask

  initial begin
    int unsigned             pick;
    logic [1:0]              op;
    logic signed [DataW-1:0] word;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-stack errors, extreme words, peek, dump, pop at reset capacity.
    send_req(OP_POP,  $urandom);
    send_req(OP_PEEK, $urandom);
    send_req(OP_DUMP, $urandom);
    send_req(OP_PUSH, WordMax);
    send_req(OP_PUSH, WordMin);
    send_req(OP_PUSH, '0);
    send_req(OP_PUSH, '1);
    send_req(OP_PEEK, '0);
    send_req(OP_DUMP, '1);
    send_req(OP_POP,  $urandom);

    // Capacity below the fill: pops see all, pushes report full until fill drops under it.
    write_capacity(7'd2);
    send_req(OP_PUSH, 32'sd5);
    send_req(OP_POP,  $urandom);
    send_req(OP_POP,  $urandom);
    send_req(OP_PUSH, 32'sh5555_5555);
    send_req(OP_PUSH, 32'shAAAA_AAAA);
    send_req(OP_DUMP, $urandom);

    // Zero capacity: every push is full; then drain past the bottom.
    write_capacity(7'd0);
    send_req(OP_PUSH, WordMax);
    send_req(OP_POP,  $urandom);
    send_req(OP_POP,  $urandom);
    send_req(OP_POP,  $urandom);

    // Random phases.
    for (int s = 0; s < NumSegs; s++) begin
      write_capacity(seg_cap[s][CapW-1:0]);
      send_idle_pct = seg_send_idle[s];
      recv_idle_pct = seg_recv_idle[s];
      for (int n = 0; n < SegItems; n++) begin
        pick = $urandom_range(99);
        if (pick < seg_push_pct[s]) op = OP_PUSH;
        else if (pick < seg_push_pct[s] + 8) op = OP_DUMP;
        else if ($urandom_range(2) == 0) op = OP_PEEK;
        else op = OP_POP;
        case ($urandom_range(15))
          0: word = WordMax;
          1: word = WordMin;
          2: word = '0;
          3: word = '1;
          default: word = $urandom;
        endcase
        send_req(op, word);
      end
    end

    // Drain and settle, then the verdict.
    req_valid <= 1'b0;
    while (shadow.pending_rsp.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (shadow.error_count == 0 && shadow.pending_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/bls_pkg.sv
rtl/bls_ram.sv
rtl/bounded_lifo_stack_top.sv
tb/tb.sv
